@@ hdl/byte_budget_fifo_retention_cache_macros.svh @@
// Assertion helpers for the cache controller (bbfc_ctrl). Every check is clocked on clk and
// held off while arst_n is low.
`ifndef BYTE_BUDGET_FIFO_RETENTION_CACHE_MACROS_SVH
`define BYTE_BUDGET_FIFO_RETENTION_CACHE_MACROS_SVH

`define BBFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define BBFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bbfc_pkg.sv @@
package bbfc_pkg;

	localparam int unsigned ENTRIES = 8192;
	localparam int unsigned SLOT_W  = $clog2(ENTRIES);
	localparam int unsigned CNT_W   = SLOT_W + 1;

	localparam logic [20:0] MAX_BODY     = 21'd2000000;
	localparam logic [31:0] BUDGET_RESET = 32'd67108864;

	localparam logic [1:0] FN_STORE  = 2'd0;
	localparam logic [1:0] FN_LOOKUP = 2'd1;
	localparam logic [1:0] FN_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_SMALL  = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [16:0] file_number;
		logic [31:0] block_offset;
		logic [20:0] body_length;
		logic [31:0] buffer_length;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] slot;
		logic [20:0] found_length;
		logic [13:0] evicted;
		logic [13:0] held_count;
		logic [31:0] held_bytes;
	} rsp_t;

	typedef struct packed {
		logic [16:0] file_number;
		logic [31:0] block_offset;
		logic [20:0] body_length;
	} rec_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
	} ram_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVCHK,
		S_EVSUB,
		S_LOOK,
		S_FIN
	} state_t;

endpackage

@@ hdl/bbfc_ram.sv @@
module bbfc_ram (
	input  logic              clk,
	input  bbfc_pkg::ram_ctl_t ctl,
	input  bbfc_pkg::rec_t    wr_data,
	output bbfc_pkg::rec_t    rd_data
);
	import bbfc_pkg::*;

	rec_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[ctl.rd_addr];
		end
	end

endmodule

@@ hdl/bbfc_ctrl.sv @@
`include "byte_budget_fifo_retention_cache_macros.svh"

module bbfc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        budget,
	input  logic               in_valid,
	output logic               in_ready,
	input  bbfc_pkg::req_t     in_data,
	output logic               res_valid,
	input  logic               res_ready,
	output bbfc_pkg::rsp_t     res
);
	import bbfc_pkg::*;

	state_t            state_q, state_d;
	req_t              req_q;
	rsp_t              res_q;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       total_q;
	logic [CNT_W-1:0]  evict_q;
	logic [CNT_W-1:0]  lk_issue_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_slot_s1;

	ram_ctl_t          ram_ctl;
	rec_t              rd_data;
	rec_t              wr_data;

	logic              reject;
	logic [32:0]       sum;
	logic              need_evict;
	logic [SLOT_W-1:0] tail;
	logic [SLOT_W-1:0] lk_addr;
	logic              hit;
	logic              lk_more;
	logic              lk_miss;

	bbfc_ram u_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	assign reject = (budget == 32'd0) || (req_q.body_length == 21'd0) ||
		({11'd0, req_q.body_length} > budget) || (req_q.body_length > MAX_BODY);
	assign sum = {1'b0, total_q} + {12'd0, req_q.body_length};
	assign need_evict = (count_q == CNT_W'(ENTRIES)) ||
		((count_q != '0) && (sum > {1'b0, budget}));
	// The oldest live record sits count entries behind the head, modulo the ring size.
	assign tail    = head_q - count_q[SLOT_W-1:0];
	assign lk_addr = head_q - SLOT_W'(1) - lk_issue_q[SLOT_W-1:0];
	assign hit = rd_vld_s1 && (rd_data.file_number == req_q.file_number) &&
		(rd_data.block_offset == req_q.block_offset);
	assign lk_more = lk_issue_q < count_q;
	assign lk_miss = !rd_vld_s1 && !lk_more;

	assign wr_data.file_number  = req_q.file_number;
	assign wr_data.block_offset = req_q.block_offset;
	assign wr_data.body_length  = req_q.body_length;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.func == FN_STORE) begin
						state_d = S_EVCHK;
					end else if (in_data.func == FN_LOOKUP) begin
						state_d = S_LOOK;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_EVCHK: begin
				if (!reject && need_evict) begin
					state_d = S_EVSUB;
				end else begin
					state_d = S_FIN;
				end
			end
			S_EVSUB: state_d = S_EVCHK;
			S_LOOK: begin
				if (hit || lk_miss) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == S_IDLE);
		res_valid       = (state_q == S_FIN);
		res             = res_q;
		ram_ctl.rd_en   = 1'b0;
		ram_ctl.rd_addr = tail;
		ram_ctl.wr_en   = 1'b0;
		ram_ctl.wr_addr = head_q;
		unique case (state_q)
			S_EVCHK: begin
				ram_ctl.rd_en = !reject && need_evict;
				ram_ctl.wr_en = !reject && !need_evict;
			end
			S_LOOK: begin
				ram_ctl.rd_en   = !hit && lk_more;
				ram_ctl.rd_addr = lk_addr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			total_q    <= '0;
			evict_q    <= '0;
			lk_issue_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						evict_q    <= '0;
						lk_issue_q <= '0;
						rd_vld_s1  <= 1'b0;
						if (in_data.func == FN_CLEAR) begin
							head_q  <= '0;
							count_q <= '0;
							total_q <= '0;
						end
					end
				end
				S_EVCHK: begin
					if (!reject && !need_evict) begin
						head_q  <= head_q + SLOT_W'(1);
						count_q <= count_q + CNT_W'(1);
						total_q <= sum[31:0];
					end
				end
				S_EVSUB: begin
					total_q <= total_q - {11'd0, rd_data.body_length};
					count_q <= count_q - CNT_W'(1);
					evict_q <= evict_q + CNT_W'(1);
				end
				S_LOOK: begin
					rd_vld_s1 <= ram_ctl.rd_en;
					if (ram_ctl.rd_en) begin
						lk_issue_q <= lk_issue_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
			res_q.status       <= ST_OK;
			res_q.slot         <= '0;
			res_q.found_length <= '0;
			res_q.evicted      <= '0;
			res_q.held_count   <= (in_data.func == FN_CLEAR) ? '0 : count_q;
			res_q.held_bytes   <= (in_data.func == FN_CLEAR) ? '0 : total_q;
		end
		if (state_q == S_LOOK) begin
			rd_slot_s1 <= lk_addr;
		end
		if (state_q == S_EVCHK) begin
			if (reject) begin
				res_q.status     <= ST_REJECT;
				res_q.slot       <= '0;
				res_q.evicted    <= '0;
				res_q.held_count <= count_q;
				res_q.held_bytes <= total_q;
			end else if (!need_evict) begin
				res_q.status     <= ST_OK;
				res_q.slot       <= head_q;
				res_q.evicted    <= evict_q;
				res_q.held_count <= count_q + CNT_W'(1);
				res_q.held_bytes <= sum[31:0];
			end
			res_q.found_length <= '0;
		end
		if (state_q == S_LOOK) begin
			res_q.evicted    <= '0;
			res_q.held_count <= count_q;
			res_q.held_bytes <= total_q;
			if (hit) begin
				res_q.slot <= rd_slot_s1;
				if (req_q.buffer_length >= {11'd0, rd_data.body_length}) begin
					res_q.status       <= ST_OK;
					res_q.found_length <= rd_data.body_length;
				end else begin
					res_q.status       <= ST_SMALL;
					res_q.found_length <= '0;
				end
			end else if (lk_miss) begin
				res_q.status       <= ST_MISS;
				res_q.slot         <= '0;
				res_q.found_length <= '0;
			end
		end
	end

	`BBFC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(ENTRIES), "ring count above capacity")
	`BBFC_ASSERT_IMP(a_empty_bytes, count_q == '0, total_q == '0, "bytes held by an empty ring")
	`BBFC_ASSERT_IMP(a_ram_port, ram_ctl.wr_en, !ram_ctl.rd_en, "record read and write collide")
	`BBFC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_q),
		"result dropped before it was taken")

endmodule

@@ hdl/byte_budget_fifo_retention_cache.sv @@
// Store: the eviction check (S_EVCHK) and subtract (S_EVSUB) states evict the oldest
// records until the new one fits, then write it. Lookup: records are read from the
// record memory and compared newest first, until a hit or the whole ring is walked.
// Clear and the unused code go straight to the result. One request is worked on at a time.
// Reset (arst_n low) empties the ring and sets the byte budget to 67108864; record
// contents are left as they are and are never read before they are written.
module byte_budget_fifo_retention_cache (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bbfc_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output bbfc_pkg::rsp_t out_data,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata
);
	import bbfc_pkg::*;

	logic [31:0] budget_q;
	logic        res_valid;
	logic        res_ready;
	rsp_t        res;
	logic        out_valid_q;
	rsp_t        out_data_q;

	bbfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.budget    (budget_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	// The output register frees the controller to take the next request while a
	// finished result still waits downstream.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
